// ===== sv/ic2d_pkg.sv =====
`default_nettype none
package ic2d_pkg;

    localparam int KW         = 5;
    localparam int CH_W       = 8;
    localparam int NCH        = 3;
    localparam int PIX_W      = NCH * CH_W;
    localparam int TAP_W      = 12;
    localparam int ROW_CFG_W  = KW * TAP_W;
    localparam int DELTA_W    = 10;
    localparam int WID_CFG_W  = 11;
    localparam int HGT_W      = 13;
    localparam int ROW_W      = HGT_W + 1;
    localparam int NBANK      = 5;
    localparam int BANK_W     = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CFG_IDX_W  = 3;

    typedef logic [PIX_W-1:0] t_pix;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_ROW0    = 3'd0,
        CFG_COEF_ROW1    = 3'd1,
        CFG_COEF_ROW2    = 3'd2,
        CFG_COEF_ROW3    = 3'd3,
        CFG_COEF_ROW4    = 3'd4,
        CFG_OFFSET_DELTA = 3'd5,
        CFG_IMAGE_WIDTH  = 3'd6,
        CFG_IMAGE_HEIGHT = 3'd7
    } t_cfg_idx;

    // one 5x5 window, already zero padded, plus position flags
    typedef struct packed {
        logic                     valid;
        logic                     eol;
        logic                     eof;
        t_pix [KW-1:0][KW-1:0]    px;
    } t_job;

    typedef struct packed {
        logic [CH_W-1:0] c0;
        logic [CH_W-1:0] c1;
        logic [CH_W-1:0] c2;
        logic            eol;
        logic            eof;
    } t_res;

endpackage
`default_nettype wire

// ===== sv/ic2d_front.sv =====
`default_nettype none
module ic2d_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_acc,
    input  logic                          i_req_type,
    input  ic2d_pkg::t_pix                i_pix,
    input  logic [$clog2(MAX_WIDTH):0]    i_width,
    input  logic [ic2d_pkg::HGT_W-1:0]    i_height,
    output logic                          o_emit,
    output ic2d_pkg::t_job                o_job
);
    import ic2d_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = COL_W + 1;

    logic [COL_W-1:0]  r_in_col, r_out_col;
    logic [ROW_W-1:0]  r_in_row, r_out_row;
    logic [BANK_W-1:0] r_slot;

    logic in_frame, ignore, adv, wr, emit, in_wrap, out_eol, out_eof;
    logic [KW-1:0] w_cmask, w_rmask;

    always_comb begin
        in_frame = r_in_row < ROW_W'(i_height);
        ignore   = i_req_type && in_frame;
        adv      = i_acc && !ignore;
        wr       = adv && !i_req_type && in_frame;
        emit     = (r_in_row > ROW_W'(2)) ||
                   ((r_in_row == ROW_W'(2)) && (r_in_col >= COL_W'(2)));
        o_emit   = emit && !ignore;
        in_wrap  = (WID_W'(r_in_col) + WID_W'(1)) >= i_width;
        out_eol  = (WID_W'(r_out_col) + WID_W'(1)) >= i_width;
        out_eof  = out_eol && ((r_out_row + ROW_W'(1)) >= ROW_W'(i_height));
        for (int c = 0; c < KW; c++) begin
            if (c < 2) w_cmask[c] = r_out_col >= COL_W'(2 - c);
            else       w_cmask[c] = (WID_W'(r_out_col) + WID_W'(c - 2)) < i_width;
        end
        // row in_row-k is inside the frame
        for (int k = 0; k < KW; k++) begin
            w_rmask[k] = (r_in_row >= ROW_W'(k)) &&
                         ((r_in_row - ROW_W'(k)) < ROW_W'(i_height));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_slot    <= '0;
        end else if (adv) begin
            if (emit && out_eof) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_slot    <= '0;
            end else begin
                if (in_wrap) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + ROW_W'(1);
                    r_slot   <= (r_slot == BANK_W'(NBANK - 1)) ? '0 : r_slot + BANK_W'(1);
                end else begin
                    r_in_col <= r_in_col + COL_W'(1);
                end
                if (emit) begin
                    if (out_eol) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + ROW_W'(1);
                    end else begin
                        r_out_col <= r_out_col + COL_W'(1);
                    end
                end
            end
        end
    end

    // line buffers: one bank per row slot, written at the slot of the current row
    t_pix w_rd [NBANK];

    for (genvar b = 0; b < NBANK; b++) begin : g_bank
        t_pix r_mem [MAX_WIDTH];
        t_pix r_rd;
        always_ff @(posedge i_clk) begin
            if (wr && (r_slot == BANK_W'(b))) r_mem[r_in_col] <= i_pix;
            r_rd <= r_mem[r_in_col];
        end
        assign w_rd[b] = r_rd;
    end

    logic              r_f1_adv, r_f1_emit, r_f1_eol, r_f1_eof, r_f1_w1;
    logic [KW-1:0]     r_f1_rmask, r_f1_cmask;
    logic [BANK_W-1:0] r_f1_slot;
    t_pix              r_f1_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_f1_adv <= 1'b0;
        else          r_f1_adv <= adv;
        r_f1_emit  <= emit;
        r_f1_eol   <= out_eol;
        r_f1_eof   <= out_eof;
        r_f1_w1    <= (i_width == WID_W'(1));
        r_f1_rmask <= w_rmask;
        r_f1_cmask <= w_cmask;
        r_f1_slot  <= r_slot;
        r_f1_pix   <= i_req_type ? '0 : i_pix;
    end

    t_pix [KW-1:0]         w_col;
    t_pix [KW-1:0][KW-1:0] r_win;

    always_comb begin
        logic [BANK_W:0]   t;
        logic [BANK_W-1:0] bi;
        t     = '0;
        bi    = '0;
        w_col = '0;
        for (int r = 0; r < KW; r++) begin
            // window row r holds image row in_row-(4-r)
            if (r == KW - 1) begin
                w_col[r] = r_f1_rmask[0] ? r_f1_pix : '0;
            end else begin
                t  = {1'b0, r_f1_slot} + (BANK_W + 1)'(NBANK - (KW - 1 - r));
                bi = (t >= (BANK_W + 1)'(NBANK)) ? BANK_W'(t - (BANK_W + 1)'(NBANK))
                                                 : BANK_W'(t);
                w_col[r] = r_f1_rmask[KW - 1 - r] ? w_rd[bi] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f1_adv) begin
            for (int r = 0; r < KW; r++) begin
                for (int c = 0; c < KW - 1; c++) r_win[r][c] <= r_win[r][c+1];
                r_win[r][KW-1] <= w_col[r];
            end
        end
    end

    always_comb begin
        o_job.valid = r_f1_adv && r_f1_emit;
        o_job.eol   = r_f1_eol;
        o_job.eof   = r_f1_eof;
        for (int r = 0; r < KW; r++) begin
            for (int c = 0; c < KW; c++) begin
                if (!r_f1_cmask[c])  o_job.px[r][c] = '0;
                else if (c == KW - 1) o_job.px[r][c] = w_col[r];
                // one-pixel rows: results lag by three items, center is the previous column
                else if (c == 2 && r_f1_w1) o_job.px[r][c] = r_win[r][KW-1];
                else                  o_job.px[r][c] = r_win[r][c+1];
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/ic2d_mac.sv =====
`default_nettype none
module ic2d_mac #(
    parameter int KERNEL_SIZE    = 5,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  ic2d_pkg::t_job                              i_job,
    input  logic [ic2d_pkg::KW-1:0][ic2d_pkg::ROW_CFG_W-1:0] i_coef,
    input  logic signed [ic2d_pkg::DELTA_W-1:0]         i_delta,
    output logic                                        o_valid,
    output ic2d_pkg::t_res                              o_res
);
    import ic2d_pkg::*;

    localparam int HALF   = KERNEL_SIZE / 2;
    localparam int PROD_W = TAP_W + CH_W + 1;
    localparam int RS_W   = PROD_W + 3;
    localparam int SUM_W  = RS_W + 4;
    localparam logic [COEF_FRAC_BITS-1:0] RND_HALF =
        COEF_FRAC_BITS'(1) << (COEF_FRAC_BITS - 1);

    logic signed [TAP_W-1:0] w_tap [KW][KW];

    always_comb begin
        for (int r = 0; r < KW; r++) begin
            for (int c = 0; c < KW; c++) begin
                if (r >= 2 - HALF && r <= 2 + HALF && c >= 2 - HALF && c <= 2 + HALF)
                    w_tap[r][c] = signed'(i_coef[r][TAP_W*c +: TAP_W]);
                else
                    w_tap[r][c] = '0;
            end
        end
    end

    // stage 1: one multiplier per tap and channel
    logic                     r_s1_valid, r_s1_eol, r_s1_eof;
    logic signed [PROD_W-1:0] r_prod [NCH][KW][KW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_s1_valid <= 1'b0;
        else          r_s1_valid <= i_job.valid;
        r_s1_eol <= i_job.eol;
        r_s1_eof <= i_job.eof;
        for (int ch = 0; ch < NCH; ch++)
            for (int r = 0; r < KW; r++)
                for (int c = 0; c < KW; c++)
                    r_prod[ch][r][c] <= PROD_W'(w_tap[r][c]) *
                        PROD_W'(signed'({1'b0, i_job.px[r][c][CH_W*ch +: CH_W]}));
    end

    // stage 2: row sums
    logic                   r_s2_valid, r_s2_eol, r_s2_eof;
    logic signed [RS_W-1:0] r_rsum [NCH][KW];

    always_ff @(posedge i_clk) begin
        logic signed [RS_W-1:0] acc;
        acc = '0;
        if (!i_rst_n) r_s2_valid <= 1'b0;
        else          r_s2_valid <= r_s1_valid;
        r_s2_eol <= r_s1_eol;
        r_s2_eof <= r_s1_eof;
        for (int ch = 0; ch < NCH; ch++) begin
            for (int r = 0; r < KW; r++) begin
                acc = '0;
                for (int c = 0; c < KW; c++) acc = acc + RS_W'(r_prod[ch][r][c]);
                r_rsum[ch][r] <= acc;
            end
        end
    end

    // stage 3: column of row sums plus offset
    logic                    r_s3_valid, r_s3_eol, r_s3_eof;
    logic signed [SUM_W-1:0] r_tot [NCH];
    logic signed [SUM_W-1:0] w_dsh;

    assign w_dsh = SUM_W'(i_delta) <<< COEF_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        logic signed [SUM_W-1:0] acc;
        acc = '0;
        if (!i_rst_n) r_s3_valid <= 1'b0;
        else          r_s3_valid <= r_s2_valid;
        r_s3_eol <= r_s2_eol;
        r_s3_eof <= r_s2_eof;
        for (int ch = 0; ch < NCH; ch++) begin
            acc = w_dsh;
            for (int r = 0; r < KW; r++) acc = acc + SUM_W'(r_rsum[ch][r]);
            r_tot[ch] <= acc;
        end
    end

    // stage 4: round half to even, clamp to 0..255
    logic [CH_W-1:0] w_sat [NCH];

    always_comb begin
        logic signed [SUM_W-1:0]      fl;
        logic signed [SUM_W-1:0]      res;
        logic [COEF_FRAC_BITS-1:0]    rem;
        logic                         up;
        fl  = '0;
        res = '0;
        rem = '0;
        up  = 1'b0;
        for (int ch = 0; ch < NCH; ch++) begin
            fl  = r_tot[ch] >>> COEF_FRAC_BITS;
            rem = r_tot[ch][COEF_FRAC_BITS-1:0];
            up  = (rem > RND_HALF) || ((rem == RND_HALF) && fl[0]);
            res = fl + SUM_W'(up);
            if (res < 0)                     w_sat[ch] = '0;
            else if (res > SUM_W'(255))      w_sat[ch] = '1;
            else                             w_sat[ch] = res[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_s3_valid;
        o_res.c0  <= w_sat[0];
        o_res.c1  <= w_sat[1];
        o_res.c2  <= w_sat[2];
        o_res.eol <= r_s3_eol;
        o_res.eof <= r_s3_eof;
    end

endmodule
`default_nettype wire

// ===== sv/ic2d_fifo.sv =====
`default_nettype none
module ic2d_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  ic2d_pkg::t_res  i_data,
    input  logic            i_rd,
    output logic            o_valid,
    output ic2d_pkg::t_res  o_data
);
    import ic2d_pkg::*;

    t_res               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_AW:0]   r_cnt;
    logic               pop;

    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            if (pop)  r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            r_cnt <= r_cnt + (FIFO_AW + 1)'(i_wr) - (FIFO_AW + 1)'(pop);
        end
    end

endmodule
`default_nettype wire

// ===== sv/image_conv2d_5x5_rgb_core.sv =====
`default_nettype none
// 5x5 per-channel correlation of a raster stream of 8-bit RGB pixels with zero
// padding, Q4.8 taps, an integer offset, round half to even and clamping to
// 0..255. One item is accepted per clock as long as results are taken; a result
// leaves through the front register, the MAC stages and the result queue after the
// item that completes its window; results trail the input by two rows and two
// pixels, so 2*width+2 drain items (req_type 1) after the last pixel flush the
// frame (3 for a one-pixel width). The rate is set by the result queue:
// the input stalls only when 8 results are accepted but not yet transferred out.
// Line storage is five banks of MAX_WIDTH pixels, one read and one write per
// clock; it needs no clearing after reset. Change sizes only between frames.
module image_conv2d_5x5_rgb_core #(
    parameter int MAX_WIDTH      = 1024,
    parameter int KERNEL_SIZE    = 5,
    parameter int COEF_FRAC_BITS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ic2d_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ic2d_pkg::ROW_CFG_W-1:0]       i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_req_type,
    input  logic [7:0]                           i_chan0_in,
    input  logic [7:0]                           i_chan1_in,
    input  logic [7:0]                           i_chan2_in,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [7:0]                           o_chan0_out,
    output logic [7:0]                           o_chan1_out,
    output logic [7:0]                           o_chan2_out,
    output logic                                 o_end_of_line,
    output logic                                 o_end_of_frame
);
    import ic2d_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = COL_W + 1;
    localparam int CMP_W = (WID_W > WID_CFG_W) ? WID_W : WID_CFG_W;

    logic [KW-1:0][ROW_CFG_W-1:0] r_coef;
    logic signed [DELTA_W-1:0]    r_delta;
    logic [WID_CFG_W-1:0]         r_width;
    logic [HGT_W-1:0]             r_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= '0;
            r_coef[1] <= '0;
            r_coef[2] <= ROW_CFG_W'(64'h1_0000_0000);
            r_coef[3] <= '0;
            r_coef[4] <= '0;
            r_delta   <= '0;
            r_width   <= WID_CFG_W'(1024);
            r_height  <= HGT_W'(768);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COEF_ROW0:    r_coef[0] <= i_cfg_data;
                CFG_COEF_ROW1:    r_coef[1] <= i_cfg_data;
                CFG_COEF_ROW2:    r_coef[2] <= i_cfg_data;
                CFG_COEF_ROW3:    r_coef[3] <= i_cfg_data;
                CFG_COEF_ROW4:    r_coef[4] <= i_cfg_data;
                CFG_OFFSET_DELTA: r_delta   <= signed'(i_cfg_data[DELTA_W-1:0]);
                CFG_IMAGE_WIDTH:  r_width   <= i_cfg_data[WID_CFG_W-1:0];
                CFG_IMAGE_HEIGHT: r_height  <= i_cfg_data[HGT_W-1:0];
                default:          r_delta   <= r_delta;
            endcase
        end
    end

    logic [WID_W-1:0] w_width;
    logic [HGT_W-1:0] w_height;

    always_comb begin
        if (r_width == '0)                            w_width = WID_W'(1);
        else if (CMP_W'(r_width) > CMP_W'(MAX_WIDTH)) w_width = WID_W'(MAX_WIDTH);
        else                                          w_width = WID_W'(r_width);
        w_height = (r_height == '0) ? HGT_W'(1) : r_height;
    end

    // results accepted but not yet transferred out
    logic [FIFO_AW:0] r_cred;
    logic             acc, emit, out_xfer, mac_valid;
    t_job             job;
    t_res             mac_res, fifo_res;

    assign o_in_ready = r_cred < (FIFO_AW + 1)'(FIFO_DEPTH);
    assign acc        = i_in_valid && o_in_ready;
    assign out_xfer   = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cred <= '0;
        else r_cred <= r_cred + (FIFO_AW + 1)'(acc && emit) - (FIFO_AW + 1)'(out_xfer);
    end

    ic2d_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_req_type (i_req_type),
        .i_pix      ({i_chan2_in, i_chan1_in, i_chan0_in}),
        .i_width    (w_width),
        .i_height   (w_height),
        .o_emit     (emit),
        .o_job      (job)
    );

    ic2d_mac #(
        .KERNEL_SIZE    (KERNEL_SIZE),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job),
        .i_coef  (r_coef),
        .i_delta (r_delta),
        .o_valid (mac_valid),
        .o_res   (mac_res)
    );

    ic2d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (mac_valid),
        .i_data  (mac_res),
        .i_rd    (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (fifo_res)
    );

    assign o_chan0_out    = fifo_res.c0;
    assign o_chan1_out    = fifo_res.c1;
    assign o_chan2_out    = fifo_res.c2;
    assign o_end_of_line  = fifo_res.eol;
    assign o_end_of_frame = fifo_res.eof;

`ifndef SYNTHESIS
    a_cred_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cred <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("result credit above queue depth");

    a_out_has_cred: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_cred != '0))
        else $error("result shown with no credit outstanding");

    a_eof_is_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_frame) |-> o_end_of_line)
        else $error("end of frame without end of line");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_cred == (FIFO_AW + 1)'(FIFO_DEPTH)))
        else $error("input stalled while queue has room");
`endif

endmodule
`default_nettype wire
